/* rtl/mcr_pkg.sv */
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; imported by mcr_front, mcr_back and the top level.
package mcr_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned RadW      = 7;
  localparam int unsigned InTdataW  = 40;   // 16 + 16 + 7, padded to whole bytes
  localparam int unsigned OutTdataW = 128;  // eight 16-bit coordinates

  // Command queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic [RadW-1:0]          radius;    // already saturated
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_x;
  } cmd_t;

endpackage

/* rtl/mcr_front.sv */
// Request front end: accepts circle requests, saturates the radius and
// holds them in a two-entry command queue. Depends on mcr_pkg.
module mcr_front #(
  parameter int unsigned MAX_RADIUS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mcr_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          cmd_valid_o,
  output mcr_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_ready_i
);
  import mcr_pkg::*;

  localparam logic [RadW-1:0] MaxRad = RadW'(MAX_RADIUS);

  cmd_t             mem_q [QDepth];
  cmd_t             wr_cmd;
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;
  logic [RadW-1:0]  rad_in;

  assign rad_in = s_axis_tdata[2*CoordW +: RadW];

  // Clamp the radius on the way in
  always_comb begin
    wr_cmd.center_x = s_axis_tdata[CoordW-1:0];
    wr_cmd.center_y = s_axis_tdata[2*CoordW-1:CoordW];
    wr_cmd.radius   = (rad_in > MaxRad) ? MaxRad : rad_in;
  end

  assign s_axis_tready = (cnt_q != QCntW'(QDepth));
  assign cmd_valid_o   = (cnt_q != '0);
  assign cmd_o         = mem_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd;
    end
  end

endmodule

/* rtl/mcr_back.sv */
// Step engine: runs the midpoint circle recurrence for one command at a time
// and drives the registered result word. Depends on mcr_pkg.
module mcr_back #(
  parameter int unsigned MAX_RADIUS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  mcr_pkg::cmd_t                  cmd_i,
  output logic                           cmd_ready_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mcr_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast
);
  import mcr_pkg::*;

  localparam int unsigned XW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CW = XW + 1;   // x and y, signed (y may dip below zero)
  localparam int unsigned DW = XW + 5;   // decision term

  localparam logic signed [CW-1:0] OneC  = CW'(1);
  localparam logic signed [DW-1:0] Three = DW'(3);
  localparam logic signed [DW-1:0] Six   = DW'(6);
  localparam logic signed [DW-1:0] Ten   = DW'(10);

  logic                     busy_q, busy_d;
  logic signed [CW-1:0]     x_q, x_d, y_q, y_d, x_n, y_n;
  logic signed [DW-1:0]     d_q, d_d, d_n, xd, yd, rd;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic signed [CoordW-1:0] xe, ye;
  logic                     step, last, load;
  logic                     ovalid_q, ovalid_d;
  logic [OutTdataW-1:0]     odata_q, odata_d;
  logic                     olast_q, olast_d;

  assign step = busy_q && (!ovalid_q || m_axis_tready);

  // Advance x, then pick the decision branch
  always_comb begin
    x_n  = x_q + OneC;
    y_n  = d_q[DW-1] ? y_q : y_q - OneC;
    xd   = $signed({{(DW-CW){x_n[CW-1]}}, x_n});
    yd   = $signed({{(DW-CW){y_n[CW-1]}}, y_n});
    d_n  = d_q[DW-1] ? d_q + (xd <<< 2) + Six : d_q + ((xd - yd) <<< 2) + Ten;
    last = (x_n > y_n);
  end

  assign cmd_ready_o = !busy_q || (step && last);
  assign load        = cmd_valid_i && cmd_ready_o;
  assign rd          = $signed({{(DW-XW){1'b0}}, cmd_i.radius[XW-1:0]});

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    d_d    = d_q;
    if (load) begin
      busy_d = 1'b1;
      x_d    = '0;
      y_d    = $signed({1'b0, cmd_i.radius[XW-1:0]});
      d_d    = Three - (rd <<< 1);
    end else if (step) begin
      busy_d = !last;
      x_d    = x_n;
      y_d    = y_n;
      d_d    = d_n;
    end
  end

  // Eight octant mirrors of the current point
  assign xe = $signed({{(CoordW-CW){x_q[CW-1]}}, x_q});
  assign ye = $signed({{(CoordW-CW){y_q[CW-1]}}, y_q});

  always_comb begin
    odata_d  = odata_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q;
    if (step) begin
      odata_d  = {cy_q - xe, cy_q + xe, cx_q - ye, cx_q + ye,
                  cy_q - ye, cy_q + ye, cx_q - xe, cx_q + xe};
      olast_d  = last;
      ovalid_d = 1'b1;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    d_q     <= d_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    if (load) begin
      cx_q <= cmd_i.center_x;
      cy_q <= cmd_i.center_y;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

/* rtl/midpoint_circle_rasterizer.sv */
// Top level of the midpoint circle rasterizer: request front end, command
// queue and step engine. Depends on mcr_pkg, mcr_front and mcr_back.
//
// Usage:
//   Slave channel (s_axis_*): one word per circle request, center and radius.
//   A radius above MAX_RADIUS is clamped to it.
//   Master channel (m_axis_*): one word per octant step, carrying the eight
//   mirrored coordinates of the current point; tlast marks the final step.
//   Startup: with an idle block an accepted request is written to the queue,
//   then loaded into the step registers, and from these the first step word
//   is registered.
//   Throughput: one octant step per cycle while m_axis_tready is high; a circle
//   of radius r takes about r/sqrt(2) + 1 steps, 46 for r = 64. The single
//   shared step unit (x, y and decision term registers) sets this. The next
//   command loads on the cycle of the last step, so back-to-back circles leave
//   no gap. The two-entry command queue keeps taking requests while a circle runs.
//   Reset: queue and engine are empty and no word is valid; s_axis_tready is
//   already high while reset is held, so hold s_axis_tvalid low until release.
//   Stall: while m_axis_tready is low with a word valid, the output word holds
//   and the step engine freezes; once the queue fills, s_axis_tready drops.
module midpoint_circle_rasterizer #(
  parameter int unsigned MAX_RADIUS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: center_x [15:0], center_y [31:16], radius [38:32], zero [39]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mcr_pkg::InTdataW-1:0]  s_axis_tdata,
  // tdata: near_right_x, near_left_x, far_down_y, far_up_y, far_right_x,
  //        far_left_x, near_down_y, near_up_y, 16 bits each from bit 0 up
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mcr_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast    // last_step
);
  import mcr_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept, clamp and queue requests
  mcr_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  // Step through each circle, one octant word per cycle unless the output stalls
  mcr_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_ready_o   (cmd_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
